@@ rtl/vaq_pkg.sv @@
// package: shared types, constants and helper functions of the vertex attribute quantizer
package vaq_pkg;

   localparam int MaxComponents = 4;
   localparam int FracBits = 16;
   localparam int MaxBits = 24;
   localparam int CompWidth = 32;
   localparam int QWidth = 24;
   localparam int BitsWidth = 6;
   localparam int ErrWidth = 2;
   localparam int CsrIdxWidth = 2;
   localparam int CsrDataWidth = 6;
   localparam int CompIdxWidth = 2;
   localparam int CountWidth = 3;
   localparam int RangeWidth = 33;
   localparam int NumWidth = 60;
   localparam int DenWidth = 35;
   localparam int DivCntWidth = 6;
   localparam int DivSteps = NumWidth;

   localparam logic [CsrIdxWidth-1:0] CSR_QUANT_BITS = 2'd0;
   localparam logic [CsrIdxWidth-1:0] CSR_INTEGER_MODE = 2'd1;
   localparam logic [CsrIdxWidth-1:0] CSR_COMPONENT_COUNT = 2'd2;
   localparam logic [CsrIdxWidth-1:0] CSR_NORMAL_MODE = 2'd3;

   localparam logic [ErrWidth-1:0] ERR_NONE = 2'd0;
   localparam logic [ErrWidth-1:0] ERR_NEG_INT = 2'd1;
   localparam logic [ErrWidth-1:0] ERR_NORMAL_RANGE = 2'd2;
   localparam logic [ErrWidth-1:0] ERR_ZERO_BITS = 2'd3;

   localparam logic OP_BOUNDS = 1'b0;
   localparam logic OP_QUANTIZE = 1'b1;

   localparam logic KIND_VECTOR = 1'b0;
   localparam logic KIND_SUMMARY = 1'b1;

   localparam logic signed [CompWidth-1:0] MostPositive = {1'b0, {(CompWidth-1){1'b1}}};
   localparam logic signed [CompWidth-1:0] MostNegative = {1'b1, {(CompWidth-1){1'b0}}};
   localparam logic signed [CompWidth-1:0] FixOne = CompWidth'(1 << FracBits);
   localparam logic signed [CompWidth-1:0] FixMinusOne = -FixOne;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_BOUNDS,
      ST_SUMMARY,
      ST_RANGE,
      ST_DIV_START,
      ST_DIV_RUN,
      ST_DIV_STORE,
      ST_OUTPUT
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic capture;
      logic bounds_update;
      logic summarize;
      logic range_calc;
      logic div_start;
      logic div_step;
      logic div_store;
      logic load_out;
      logic [CompIdxWidth-1:0] comp_sel;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic op_quant;
      logic last;
      logic div_needed;
      logic div_done;
      logic [CountWidth-1:0] used_count;
   } status_type;

   // integer part, truncated toward zero
   function automatic logic signed [CompWidth-1:0] int_part(
      input logic signed [CompWidth-1:0] v);
      logic signed [CompWidth-1:0] sh;
      logic [FracBits-1:0] fr;
      begin
         sh = v >>> FracBits;
         fr = v[FracBits-1:0];
         if (v[CompWidth-1] && (fr != '0)) begin
            int_part = sh + CompWidth'(1);
         end else begin
            int_part = sh;
         end
      end
   endfunction

   // number of significant bits of a non-negative value
   function automatic logic [BitsWidth-1:0] bit_length(
      input logic signed [CompWidth-1:0] v);
      logic [BitsWidth-1:0] n;
      begin
         n = '0;
         for (int i = 0; i < CompWidth; i++) begin
            if (v[i]) begin
               n = BitsWidth'(i + 1);
            end
         end
         bit_length = v[CompWidth-1] ? '0 : n;
      end
   endfunction

endpackage

@@ rtl/vaq_if.sv @@
// interface: valid/ready channel carrying one payload
interface vaq_if #(
   parameter type payload_type = logic
);
   logic valid;
   logic ready;
   payload_type payload;

   modport source(output valid, output payload, input ready);
   modport sink(input valid, input payload, output ready);
endinterface

@@ rtl/vertex_attribute_quantizer.sv @@
// top level: vertex attribute quantizer with bounds and quantize passes
// one request at a time; bounds request without last: bounds, then idle, no response
// summary: bounds, summary, output; quantize: bounds, range, then per used component
// the shared divider's start, run and store when a division is needed, then output
// the divider is restoring, one quotient bit per cycle over a 60-bit numerator
// reset (synchronous, active high): bounds cleared, bit count -1, registers to defaults
module vertex_attribute_quantizer (
   input logic clock,
   input logic reset,
   input logic csr_write,
   input logic [vaq_pkg::CsrIdxWidth-1:0] csr_index,
   input logic [vaq_pkg::CsrDataWidth-1:0] csr_data,
   input logic req_valid,
   output logic req_ready,
   input logic req_operation,
   input logic signed [vaq_pkg::CompWidth-1:0] req_comp0,
   input logic signed [vaq_pkg::CompWidth-1:0] req_comp1,
   input logic signed [vaq_pkg::CompWidth-1:0] req_comp2,
   input logic signed [vaq_pkg::CompWidth-1:0] req_comp3,
   input logic req_last,
   output logic rsp_valid,
   input logic rsp_ready,
   output logic rsp_kind,
   output logic [vaq_pkg::QWidth-1:0] rsp_q0,
   output logic [vaq_pkg::QWidth-1:0] rsp_q1,
   output logic [vaq_pkg::QWidth-1:0] rsp_q2,
   output logic [vaq_pkg::QWidth-1:0] rsp_q3,
   output logic signed [vaq_pkg::BitsWidth-1:0] rsp_bits_used,
   output logic [vaq_pkg::ErrWidth-1:0] rsp_error
);

   // configuration registers
   logic signed [vaq_pkg::BitsWidth-1:0] quant_bits_ff;
   logic integer_mode_ff;
   logic [vaq_pkg::CountWidth-1:0] component_count_ff;
   logic normal_mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         quant_bits_ff <= vaq_pkg::BitsWidth'(12);
         integer_mode_ff <= 1'b0;
         component_count_ff <= vaq_pkg::CountWidth'(3);
         normal_mode_ff <= 1'b0;
      end else if (csr_write) begin
         unique case (csr_index)
            vaq_pkg::CSR_QUANT_BITS: quant_bits_ff <= csr_data;
            vaq_pkg::CSR_INTEGER_MODE: integer_mode_ff <= csr_data[0];
            vaq_pkg::CSR_COMPONENT_COUNT:
               component_count_ff <= csr_data[vaq_pkg::CountWidth-1:0];
            vaq_pkg::CSR_NORMAL_MODE: normal_mode_ff <= csr_data[0];
            default: ;
         endcase
      end
   end

   // request components gathered into an array for the datapath
   logic signed [vaq_pkg::CompWidth-1:0] comp_arr [vaq_pkg::MaxComponents];
   logic [vaq_pkg::QWidth-1:0] q_arr [vaq_pkg::MaxComponents];
   assign comp_arr[0] = req_comp0;
   assign comp_arr[1] = req_comp1;
   assign comp_arr[2] = req_comp2;
   assign comp_arr[3] = req_comp3;
   assign rsp_q0 = q_arr[0];
   assign rsp_q1 = q_arr[1];
   assign rsp_q2 = q_arr[2];
   assign rsp_q3 = q_arr[3];

   vaq_pkg::cmd_type cmd;
   vaq_pkg::status_type status;

   // sequencer
   vaq_ctrl u_ctrl (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .status(status),
      .cmd(cmd)
   );

   // bounds, summary and divider
   vaq_datapath u_datapath (
      .clock(clock),
      .reset(reset),
      .cmd(cmd),
      .status(status),
      .req_operation(req_operation),
      .req_comp(comp_arr),
      .req_last(req_last),
      .cfg_quant_bits(quant_bits_ff),
      .cfg_integer_mode(integer_mode_ff),
      .cfg_component_count(component_count_ff),
      .cfg_normal_mode(normal_mode_ff),
      .out_kind(rsp_kind),
      .out_q(q_arr),
      .out_bits_used(rsp_bits_used),
      .out_error(rsp_error)
   );

   // summary responses carry zero quantized fields
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == vaq_pkg::KIND_SUMMARY |-> rsp_q0 == '0 && rsp_q3 == '0)
      else $error("summary with nonzero q");

   // an error always comes with bits_used -1
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_error != vaq_pkg::ERR_NONE |-> rsp_bits_used == -6'sd1)
      else $error("error with bit count");

   // a stalled response keeps its payload
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_q0) && $stable(rsp_kind))
      else $error("response changed under stall");

endmodule

@@ rtl/vaq_ctrl.sv @@
// controller: sequences bounds, summary and the serial divider over components
module vaq_ctrl (
   input logic clock,
   input logic reset,
   input logic req_valid,
   output logic req_ready,
   output logic rsp_valid,
   input logic rsp_ready,
   input vaq_pkg::status_type status,
   output vaq_pkg::cmd_type cmd
);

   vaq_pkg::state_type state_ff, state_in;
   logic [vaq_pkg::CompIdxWidth-1:0] comp_ff, comp_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic comp_last;

   assign comp_last = ({1'b0, comp_ff} == (status.used_count - vaq_pkg::CountWidth'(1)));
   assign rsp_valid = rsp_valid_ff;
   // a new request may enter in idle once the output register is free or being drained
   assign req_ready = (state_ff == vaq_pkg::ST_IDLE) && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         vaq_pkg::ST_IDLE: begin
            if (req_valid && req_ready) begin
               state_in = vaq_pkg::ST_BOUNDS;
            end
         end
         vaq_pkg::ST_BOUNDS: begin
            if (status.op_quant) begin
               state_in = vaq_pkg::ST_RANGE;
            end else if (status.last) begin
               state_in = vaq_pkg::ST_SUMMARY;
            end else begin
               state_in = vaq_pkg::ST_IDLE;
            end
         end
         vaq_pkg::ST_SUMMARY: state_in = vaq_pkg::ST_OUTPUT;
         vaq_pkg::ST_RANGE: begin
            state_in = status.div_needed ? vaq_pkg::ST_DIV_START : vaq_pkg::ST_OUTPUT;
         end
         vaq_pkg::ST_DIV_START: state_in = vaq_pkg::ST_DIV_RUN;
         vaq_pkg::ST_DIV_RUN: begin
            if (status.div_done) begin
               state_in = vaq_pkg::ST_DIV_STORE;
            end
         end
         vaq_pkg::ST_DIV_STORE: begin
            state_in = comp_last ? vaq_pkg::ST_OUTPUT : vaq_pkg::ST_DIV_START;
         end
         vaq_pkg::ST_OUTPUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               state_in = vaq_pkg::ST_IDLE;
            end
         end
         default: state_in = vaq_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      cmd.comp_sel = comp_ff;
      comp_in = comp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      unique case (state_ff)
         vaq_pkg::ST_IDLE: begin
            cmd.capture = req_valid && req_ready;
            comp_in = '0;
         end
         vaq_pkg::ST_BOUNDS: cmd.bounds_update = !status.op_quant;
         vaq_pkg::ST_SUMMARY: cmd.summarize = 1'b1;
         vaq_pkg::ST_RANGE: cmd.range_calc = 1'b1;
         vaq_pkg::ST_DIV_START: cmd.div_start = 1'b1;
         vaq_pkg::ST_DIV_RUN: cmd.div_step = 1'b1;
         vaq_pkg::ST_DIV_STORE: begin
            cmd.div_store = 1'b1;
            comp_in = comp_ff + vaq_pkg::CompIdxWidth'(1);
         end
         vaq_pkg::ST_OUTPUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load_out = 1'b1;
               rsp_valid_in = 1'b1;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= vaq_pkg::ST_IDLE;
         comp_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         comp_ff <= comp_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

@@ rtl/vaq_datapath.sv @@
// datapath: bounds registers, summary logic, range and restoring divider
module vaq_datapath (
   input logic clock,
   input logic reset,
   input vaq_pkg::cmd_type cmd,
   output vaq_pkg::status_type status,
   input logic req_operation,
   input logic signed [vaq_pkg::CompWidth-1:0] req_comp [vaq_pkg::MaxComponents],
   input logic req_last,
   input logic signed [vaq_pkg::BitsWidth-1:0] cfg_quant_bits,
   input logic cfg_integer_mode,
   input logic [vaq_pkg::CountWidth-1:0] cfg_component_count,
   input logic cfg_normal_mode,
   output logic out_kind,
   output logic [vaq_pkg::QWidth-1:0] out_q [vaq_pkg::MaxComponents],
   output logic signed [vaq_pkg::BitsWidth-1:0] out_bits_used,
   output logic [vaq_pkg::ErrWidth-1:0] out_error
);

   localparam int N = vaq_pkg::MaxComponents;
   localparam int CW = vaq_pkg::CompWidth;

   logic signed [CW-1:0] comp_ff [N];
   logic op_ff, last_ff;
   logic signed [CW-1:0] low_ff [N];
   logic signed [CW-1:0] high_ff [N];
   logic pass_open_ff;
   logic signed [vaq_pkg::BitsWidth-1:0] bits_ff, bits_in;
   logic [vaq_pkg::ErrWidth-1:0] err_ff, err_in;
   logic [vaq_pkg::CountWidth-1:0] used;
   logic signed [vaq_pkg::BitsWidth-1:0] qb;
   logic [vaq_pkg::QWidth-1:0] q_ff [N];
   logic [vaq_pkg::QWidth-1:0] mask;
   logic signed [vaq_pkg::RangeWidth-1:0] range_ff, range_in;
   logic quant_ok;
   logic [vaq_pkg::NumWidth-1:0] num_ff;
   logic [vaq_pkg::DenWidth-1:0] den_ff;
   logic [vaq_pkg::DenWidth:0] rem_ff;
   logic [vaq_pkg::NumWidth-1:0] quo_ff;
   logic [vaq_pkg::DivCntWidth-1:0] cnt_ff;
   logic num_neg_ff;
   logic signed [vaq_pkg::RangeWidth-1:0] dsub;
   logic signed [vaq_pkg::RangeWidth-1:0] mn_sel;
   logic signed [vaq_pkg::NumWidth:0] prod;
   logic [vaq_pkg::DenWidth:0] rem_sh;
   logic [vaq_pkg::NumWidth-1:0] quo_fix;
   logic out_kind_ff;
   logic [vaq_pkg::QWidth-1:0] out_q_ff [N];
   logic signed [vaq_pkg::BitsWidth-1:0] out_bits_ff;
   logic [vaq_pkg::ErrWidth-1:0] out_err_ff;

   always_comb begin
      if (cfg_component_count == '0) begin
         used = vaq_pkg::CountWidth'(1);
      end else if (cfg_component_count > vaq_pkg::CountWidth'(N)) begin
         used = vaq_pkg::CountWidth'(N);
      end else begin
         used = cfg_component_count;
      end
      if (cfg_quant_bits < 0) begin
         qb = -vaq_pkg::BitsWidth'(1);
      end else if (cfg_quant_bits > vaq_pkg::BitsWidth'(vaq_pkg::MaxBits)) begin
         qb = vaq_pkg::BitsWidth'(vaq_pkg::MaxBits);
      end else begin
         qb = cfg_quant_bits;
      end
   end

   assign mask = vaq_pkg::QWidth'((25'd1 << bits_ff[4:0]) - 25'd1);
   assign quant_ok = !bits_ff[vaq_pkg::BitsWidth-1] && (err_ff == vaq_pkg::ERR_NONE);

   // summary of the closed bounds pass
   always_comb begin
      logic signed [CW-1:0] mn_i, mx_i, a, b;
      logic normal_bad;
      logic [vaq_pkg::BitsWidth-1:0] nb;
      mn_i = vaq_pkg::MostPositive;
      mx_i = vaq_pkg::MostNegative;
      normal_bad = 1'b0;
      for (int i = 0; i < N; i++) begin
         a = vaq_pkg::int_part(low_ff[i]);
         b = vaq_pkg::int_part(high_ff[i]);
         if (i < int'(used)) begin
            if (a < mn_i) mn_i = a;
            if (b > mx_i) mx_i = b;
            if (low_ff[i] < vaq_pkg::FixMinusOne || high_ff[i] > vaq_pkg::FixOne) begin
               normal_bad = 1'b1;
            end
         end
      end
      nb = vaq_pkg::bit_length(mx_i);
      bits_in = -vaq_pkg::BitsWidth'(1);
      err_in = vaq_pkg::ERR_NONE;
      if (qb >= 0) begin
         if (cfg_integer_mode) begin
            if (mn_i < 0) begin
               err_in = vaq_pkg::ERR_NEG_INT;
            end else if (qb == 0) begin
               bits_in = (nb > vaq_pkg::BitsWidth'(vaq_pkg::MaxBits))
                  ? vaq_pkg::BitsWidth'(vaq_pkg::MaxBits) : nb;
            end else begin
               bits_in = qb;
            end
         end else if (qb == 0) begin
            err_in = vaq_pkg::ERR_ZERO_BITS;
         end else if (cfg_normal_mode && normal_bad) begin
            err_in = vaq_pkg::ERR_NORMAL_RANGE;
         end else begin
            bits_in = qb;
         end
      end
   end

   // largest extent over used components, or 2.0 in normal mode
   always_comb begin
      logic signed [vaq_pkg::RangeWidth-1:0] d;
      range_in = '0;
      for (int i = 0; i < N; i++) begin
         d = vaq_pkg::RangeWidth'(high_ff[i]) - vaq_pkg::RangeWidth'(low_ff[i]);
         if (i < int'(used)) begin
            if (i == 0 || d > range_in) range_in = d;
         end
      end
      if (cfg_normal_mode) begin
         range_in = vaq_pkg::RangeWidth'(2) <<< vaq_pkg::FracBits;
      end
   end

   // numerator 2*d*m + range, denominator 2*range
   always_comb begin
      mn_sel = cfg_normal_mode ? vaq_pkg::RangeWidth'(vaq_pkg::FixMinusOne)
                               : vaq_pkg::RangeWidth'(low_ff[cmd.comp_sel]);
      dsub = vaq_pkg::RangeWidth'(comp_ff[cmd.comp_sel]) - mn_sel;
      prod = (vaq_pkg::NumWidth+1)'(dsub) * $signed({1'b0, mask})
           + (vaq_pkg::NumWidth+1)'(dsub) * $signed({1'b0, mask})
           + (vaq_pkg::NumWidth+1)'(range_ff);
   end

   assign rem_sh = {rem_ff[vaq_pkg::DenWidth-1:0], num_ff[vaq_pkg::NumWidth-1]};
   // negative numerator: magnitude quotient rounded up, whose negation is the floor
   assign quo_fix = num_neg_ff ? (quo_ff + vaq_pkg::NumWidth'(rem_ff != '0)) : quo_ff;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff <= req_operation;
         last_ff <= req_last;
         for (int i = 0; i < N; i++) comp_ff[i] <= req_comp[i];
      end
      if (cmd.range_calc) begin
         range_ff <= range_in;
         for (int i = 0; i < N; i++) begin
            if (quant_ok && cfg_integer_mode && (i < int'(used))) begin
               if (vaq_pkg::int_part(comp_ff[i]) < 0) begin
                  q_ff[i] <= '0;
               end else if (vaq_pkg::int_part(comp_ff[i]) > $signed({8'd0, mask})) begin
                  q_ff[i] <= mask;
               end else begin
                  q_ff[i] <= vaq_pkg::QWidth'(vaq_pkg::int_part(comp_ff[i]));
               end
            end else begin
               q_ff[i] <= '0;
            end
         end
      end
      if (cmd.div_start) begin
         num_neg_ff <= prod[vaq_pkg::NumWidth];
         num_ff <= prod[vaq_pkg::NumWidth] ? vaq_pkg::NumWidth'(-prod)
                                           : vaq_pkg::NumWidth'(prod);
         den_ff <= vaq_pkg::DenWidth'({range_ff, 1'b0});
         rem_ff <= '0;
         quo_ff <= '0;
         cnt_ff <= '0;
      end
      if (cmd.div_step) begin
         num_ff <= num_ff << 1;
         cnt_ff <= cnt_ff + vaq_pkg::DivCntWidth'(1);
         if (rem_sh >= {1'b0, den_ff}) begin
            rem_ff <= rem_sh - {1'b0, den_ff};
            quo_ff <= {quo_ff[vaq_pkg::NumWidth-2:0], 1'b1};
         end else begin
            rem_ff <= rem_sh;
            quo_ff <= {quo_ff[vaq_pkg::NumWidth-2:0], 1'b0};
         end
      end
      if (cmd.div_store) begin
         if (num_neg_ff && quo_fix != '0) begin
            q_ff[cmd.comp_sel] <= '0;
         end else if (quo_fix > vaq_pkg::NumWidth'(mask)) begin
            q_ff[cmd.comp_sel] <= mask;
         end else begin
            q_ff[cmd.comp_sel] <= vaq_pkg::QWidth'(quo_fix);
         end
      end
      if (cmd.load_out) begin
         out_kind_ff <= op_ff ? vaq_pkg::KIND_VECTOR : vaq_pkg::KIND_SUMMARY;
         out_bits_ff <= bits_ff;
         out_err_ff <= err_ff;
         for (int i = 0; i < N; i++) out_q_ff[i] <= op_ff ? q_ff[i] : '0;
      end
   end

   // bounds and summary state
   always_ff @(posedge clock) begin
      if (reset) begin
         pass_open_ff <= 1'b0;
         bits_ff <= -vaq_pkg::BitsWidth'(1);
         err_ff <= vaq_pkg::ERR_NONE;
         for (int i = 0; i < N; i++) begin
            low_ff[i] <= vaq_pkg::MostPositive;
            high_ff[i] <= vaq_pkg::MostNegative;
         end
      end else begin
         if (cmd.bounds_update) begin
            pass_open_ff <= !last_ff;
            for (int i = 0; i < N; i++) begin
               if (i < int'(used)) begin
                  if (!pass_open_ff || comp_ff[i] < low_ff[i]) low_ff[i] <= comp_ff[i];
                  if (!pass_open_ff || comp_ff[i] > high_ff[i]) high_ff[i] <= comp_ff[i];
               end else if (!pass_open_ff) begin
                  low_ff[i] <= vaq_pkg::MostPositive;
                  high_ff[i] <= vaq_pkg::MostNegative;
               end
            end
         end
         if (cmd.range_calc) pass_open_ff <= 1'b0;
         if (cmd.summarize) begin
            bits_ff <= bits_in;
            err_ff <= err_in;
         end
      end
   end

   assign status.op_quant = op_ff;
   assign status.last = last_ff;
   assign status.div_needed = quant_ok && !cfg_integer_mode && (range_in > 0);
   assign status.div_done = (cnt_ff == vaq_pkg::DivCntWidth'(vaq_pkg::DivSteps - 1))
                            && cmd.div_step;
   assign status.used_count = used;

   assign out_kind = out_kind_ff;
   assign out_q = out_q_ff;
   assign out_bits_used = out_bits_ff;
   assign out_error = out_err_ff;

endmodule

@@ tb/sv/vaq_test_pkg.sv @@
// package: request and response layouts used on the quantizer test channels
`timescale 1ns / 1ps
package vaq_test_pkg;

   typedef struct packed {
      logic operation;
      logic [vaq_pkg::MaxComponents-1:0][vaq_pkg::CompWidth-1:0] comp;
      logic last;
   } vaq_request_t;

   typedef struct packed {
      logic kind;
      logic [vaq_pkg::MaxComponents-1:0][vaq_pkg::QWidth-1:0] q;
      logic signed [vaq_pkg::BitsWidth-1:0] bits_used;
      logic [vaq_pkg::ErrWidth-1:0] error;
   } vaq_response_t;

endpackage

@@ tb/sv/vaq_quant_checker.sv @@
// checker: predicts quantizer responses from observed requests and compares them
`timescale 1ns / 1ps
module vaq_quant_checker
   import vaq_pkg::*;
   import vaq_test_pkg::*;
(
   input logic clock,
   input logic reset,
   input logic csr_write,
   input logic [CsrIdxWidth-1:0] csr_index,
   input logic [CsrDataWidth-1:0] csr_data,
   vaq_if req_ch,
   vaq_if rsp_ch,
   output int failures,
   output int pending
);

   vaq_response_t expected_rsp[$];

   logic signed [CompWidth-1:0] min_bound[MaxComponents];
   logic signed [CompWidth-1:0] max_bound[MaxComponents];
   int bits_in_force;
   logic [ErrWidth-1:0] stored_err;
   bit bounds_open;

   logic signed [BitsWidth-1:0] cfg_bits;
   logic cfg_integer;
   logic [CountWidth-1:0] cfg_count;
   logic cfg_normal;

   function automatic int active_count();
      if (cfg_count < 1) return 1;
      if (cfg_count > MaxComponents) return MaxComponents;
      return int'(cfg_count);
   endfunction

   function automatic longint floor_quot(longint n, longint d);
      longint q;
      q = n / d;
      if ((n % d) != 0 && n < 0) q--;
      return q;
   endfunction

   function automatic void close_bounds();
      int qb;
      int cnt;
      int nb;
      longint lo_i;
      longint hi_i;
      longint a;
      longint one;
      cnt = active_count();
      qb = int'(cfg_bits);
      if (qb > MaxBits) qb = MaxBits;
      bits_in_force = -1;
      stored_err = ERR_NONE;
      if (qb < 0) return;
      if (cfg_integer) begin
         lo_i = 64'sh7fffffffffffffff;
         hi_i = -64'sh7fffffffffffffff - 1;
         for (int i = 0; i < cnt; i++) begin
            a = longint'(min_bound[i]) / 65536;
            if (a < lo_i) lo_i = a;
            a = longint'(max_bound[i]) / 65536;
            if (a > hi_i) hi_i = a;
         end
         if (lo_i < 0) begin
            stored_err = ERR_NEG_INT;
         end else if (qb == 0) begin
            nb = 0;
            while (hi_i > 0) begin
               nb++;
               hi_i = hi_i >> 1;
            end
            bits_in_force = (nb > MaxBits) ? MaxBits : nb;
         end else begin
            bits_in_force = qb;
         end
         return;
      end
      if (qb == 0) begin
         stored_err = ERR_ZERO_BITS;
         return;
      end
      if (cfg_normal) begin
         one = 64'sd1 << FracBits;
         for (int i = 0; i < cnt; i++) begin
            if (longint'(min_bound[i]) < -one || longint'(max_bound[i]) > one) begin
               stored_err = ERR_NORMAL_RANGE;
               return;
            end
         end
      end
      bits_in_force = qb;
   endfunction

   function automatic void quantize_vector(vaq_request_t r, ref vaq_response_t y);
      int cnt;
      longint top;
      longint span;
      longint d;
      longint base;
      longint v;
      longint res;
      cnt = active_count();
      if (bits_in_force < 0 || stored_err != ERR_NONE) return;
      top = (64'sd1 << bits_in_force) - 1;
      if (cfg_integer) begin
         for (int i = 0; i < cnt; i++) begin
            v = longint'($signed(r.comp[i])) / 65536;
            if (v < 0) v = 0;
            if (v > top) v = top;
            y.q[i] = QWidth'(v);
         end
         return;
      end
      span = 0;
      if (cfg_normal) begin
         span = 64'sd2 << FracBits;
      end else begin
         for (int i = 0; i < cnt; i++) begin
            d = longint'(max_bound[i]) - longint'(min_bound[i]);
            if (i == 0 || d > span) span = d;
         end
      end
      if (span <= 0) return;
      for (int i = 0; i < cnt; i++) begin
         base = cfg_normal ? -(64'sd1 << FracBits) : longint'(min_bound[i]);
         d = longint'($signed(r.comp[i])) - base;
         res = floor_quot(2 * d * top + span, 2 * span);
         if (res < 0) res = 0;
         if (res > top) res = top;
         y.q[i] = QWidth'(res);
      end
   endfunction

   // returns 1 when the request produces a response
   function automatic bit predict_response(vaq_request_t r, ref vaq_response_t y);
      int cnt;
      cnt = active_count();
      y = '0;
      if (r.operation == OP_BOUNDS) begin
         if (!bounds_open) begin
            for (int i = 0; i < MaxComponents; i++) begin
               min_bound[i] = MostPositive;
               max_bound[i] = MostNegative;
            end
         end
         bounds_open = 1;
         for (int i = 0; i < cnt; i++) begin
            if ($signed(r.comp[i]) < min_bound[i]) min_bound[i] = r.comp[i];
            if ($signed(r.comp[i]) > max_bound[i]) max_bound[i] = r.comp[i];
         end
         if (!r.last) return 0;
         bounds_open = 0;
         close_bounds();
         y.kind = KIND_SUMMARY;
      end else begin
         bounds_open = 0;
         quantize_vector(r, y);
         y.kind = KIND_VECTOR;
      end
      y.bits_used = BitsWidth'(bits_in_force);
      y.error = stored_err;
      return 1;
   endfunction

   task automatic compare_field(string name, longint exp_v, longint act_v);
      if (exp_v != act_v) begin
         $error("%s mismatch: expected %0d, actual %0d", name, exp_v, act_v);
         failures++;
      end
   endtask

   always @(posedge clock) begin
      vaq_response_t y;
      vaq_response_t got;
      if (reset) begin
         for (int i = 0; i < MaxComponents; i++) begin
            min_bound[i] = MostPositive;
            max_bound[i] = MostNegative;
         end
         bits_in_force = -1;
         stored_err = ERR_NONE;
         bounds_open = 0;
         cfg_bits = 6'sd12;
         cfg_integer = 0;
         cfg_count = 3'd3;
         cfg_normal = 0;
         expected_rsp.delete();
      end else begin
         if (csr_write) begin
            case (csr_index)
               CSR_QUANT_BITS: cfg_bits = csr_data;
               CSR_INTEGER_MODE: cfg_integer = csr_data[0];
               CSR_COMPONENT_COUNT: cfg_count = csr_data[CountWidth-1:0];
               CSR_NORMAL_MODE: cfg_normal = csr_data[0];
               default: ;
            endcase
         end
         if (req_ch.valid && req_ch.ready) begin
            if (predict_response(req_ch.payload, y)) expected_rsp.push_back(y);
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            got = rsp_ch.payload;
            if (expected_rsp.size() == 0) begin
               $error("response with nothing expected: kind %0d", got.kind);
               failures++;
            end else begin
               y = expected_rsp.pop_front();
               compare_field("kind", y.kind, got.kind);
               for (int i = 0; i < MaxComponents; i++) begin
                  compare_field($sformatf("q%0d", i), y.q[i], got.q[i]);
               end
               compare_field("bits_used", y.bits_used, got.bits_used);
               compare_field("error", y.error, got.error);
            end
         end
      end
      pending = expected_rsp.size();
   end

   initial begin
      failures = 0;
      pending = 0;
   end

endmodule

@@ tb/sv/vertex_attribute_quantizer_test.sv @@
// testbench top: stimulus, handshake pacing and verdict for the vertex attribute quantizer
`timescale 1ns / 1ps
module vertex_attribute_quantizer_test;
   import vaq_pkg::*;
   import vaq_test_pkg::*;

   localparam int IdleLimit = 6000;   // quiet cycles before the watchdog fires
   localparam int HoldCycles = 1500;  // long response hold-off for back pressure
   localparam int ItemGoal = 1100;

   logic clock;
   logic reset;
   logic csr_write;
   logic [CsrIdxWidth-1:0] csr_index;
   logic [CsrDataWidth-1:0] csr_data;

   vaq_if #(.payload_type(vaq_request_t)) req_ch ();
   vaq_if #(.payload_type(vaq_response_t)) rsp_ch ();

   int failures;
   int pending;
   int requests_sent;
   int settings_used;
   int send_idle_pct;
   int recv_idle_pct;
   bit hold_request;
   int quiet_cycles;

   vertex_attribute_quantizer u_dut (
      .clock(clock),
      .reset(reset),
      .csr_write(csr_write),
      .csr_index(csr_index),
      .csr_data(csr_data),
      .req_valid(req_ch.valid),
      .req_ready(req_ch.ready),
      .req_operation(req_ch.payload.operation),
      .req_comp0(req_ch.payload.comp[0]),
      .req_comp1(req_ch.payload.comp[1]),
      .req_comp2(req_ch.payload.comp[2]),
      .req_comp3(req_ch.payload.comp[3]),
      .req_last(req_ch.payload.last),
      .rsp_valid(rsp_ch.valid),
      .rsp_ready(rsp_ch.ready),
      .rsp_kind(rsp_ch.payload.kind),
      .rsp_q0(rsp_ch.payload.q[0]),
      .rsp_q1(rsp_ch.payload.q[1]),
      .rsp_q2(rsp_ch.payload.q[2]),
      .rsp_q3(rsp_ch.payload.q[3]),
      .rsp_bits_used(rsp_ch.payload.bits_used),
      .rsp_error(rsp_ch.payload.error)
   );

   vaq_quant_checker u_checker (
      .clock(clock),
      .reset(reset),
      .csr_write(csr_write),
      .csr_index(csr_index),
      .csr_data(csr_data),
      .req_ch(req_ch),
      .rsp_ch(rsp_ch),
      .failures(failures),
      .pending(pending)
   );

   // 10 ns clock
   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   // response side: random stalls, plus one long hold-off on request
   initial begin
      int hold_left;
      hold_left = 0;
      rsp_ch.ready = 0;
      forever begin
         @(posedge clock);
         if (hold_request && hold_left == 0) begin
            hold_left = HoldCycles;
            hold_request = 0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready <= 0;
         end else begin
            rsp_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
         end
      end
   end

   // watchdog: cycles with no handshake on either channel
   initial begin
      quiet_cycles = 0;
      forever begin
         @(posedge clock);
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= IdleLimit) begin
            $display("timeout: no handshake for %0d cycles", IdleLimit);
            $display("vertex_attribute_quantizer_test: FAIL");
            $finish;
         end
      end
   end

   // one request, held until accepted; random sender gaps before it
   // valid stays up into the next request and drops only while idling or in stop_sending
   task automatic send(logic op, logic [31:0] c0, logic [31:0] c1, logic [31:0] c2,
                       logic [31:0] c3, logic last);
      vaq_request_t r;
      r.operation = op;
      r.comp[0] = c0;
      r.comp[1] = c1;
      r.comp[2] = c2;
      r.comp[3] = c3;
      r.last = last;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_ch.valid <= 0;
         @(posedge clock);
      end
      req_ch.valid <= 1;
      req_ch.payload <= r;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      requests_sent++;
   endtask

   // stop offering and let the checker see the last accepted request
   task automatic stop_sending();
      req_ch.valid <= 0;
      @(posedge clock);
   endtask

   // register writes only with the block drained
   task automatic configure(logic signed [5:0] qb, logic im, logic [2:0] cc, logic nm);
      stop_sending();
      wait (pending == 0);
      repeat (20) @(posedge clock);
      csr_write <= 1;
      csr_index <= CSR_QUANT_BITS;
      csr_data <= qb;
      @(posedge clock);
      csr_index <= CSR_INTEGER_MODE;
      csr_data <= {5'd0, im};
      @(posedge clock);
      csr_index <= CSR_COMPONENT_COUNT;
      csr_data <= {3'd0, cc};
      @(posedge clock);
      csr_index <= CSR_NORMAL_MODE;
      csr_data <= {5'd0, nm};
      @(posedge clock);
      csr_write <= 0;
      settings_used++;
   endtask

   // component value shaped to the active mode
   function automatic logic [31:0] pick_comp(int shape);
      logic [31:0] v;
      case (shape)
         1: v = $urandom_range(0, 131072 + 800) - 65536 - 400;       // around unit normals
         2: begin                                                    // mostly non-negative integers
            v = ($urandom_range(0, (1 << $urandom_range(0, 14)) - 1) << 16)
                | $urandom_range(0, 65535);
            if ($urandom_range(0, 39) == 0) v = -v;
         end
         3: v = $urandom_range(0, 1 << 22) - (1 << 21);
         default: v = $urandom;
      endcase
      return v;
   endfunction

   // one bounds pass followed by a run of quantize requests
   task automatic run_pass_pair(int shape);
      int n;
      bit drop_last;
      n = $urandom_range(1, 6);
      drop_last = ($urandom_range(0, 9) == 0);   // broken pass: closed by a quantize
      for (int i = 0; i < n; i++)
         send(OP_BOUNDS, pick_comp(shape), pick_comp(shape), pick_comp(shape),
              pick_comp(shape), (i == n - 1) && !drop_last);
      n = $urandom_range(1, 6);
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(0, 19) == 0)
            send($urandom_range(0, 1), $urandom, $urandom, $urandom, $urandom,
                 $urandom_range(0, 1));          // noise
         else
            send(OP_QUANTIZE, pick_comp(shape), pick_comp(shape), pick_comp(shape),
                 pick_comp(shape), $urandom_range(0, 1));
      end
   endtask

   initial begin
      logic signed [5:0] qb;
      logic im;
      logic nm;
      int shape;
      int stage_goal;
      reset = 1;
      csr_write = 0;
      csr_index = CSR_QUANT_BITS;
      csr_data = '0;
      req_ch.valid = 0;
      req_ch.payload = '0;
      requests_sent = 0;
      settings_used = 0;
      send_idle_pct = 0;
      recv_idle_pct = 0;
      hold_request = 0;
      repeat (8) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: default registers, quantize before any summary
      send(OP_QUANTIZE, 32'h0001_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h0, 1'b0);
      // extreme bounds, then quantize extremes
      send(OP_BOUNDS, 32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'hffff_ffff, 1'b0);
      send(OP_BOUNDS, 32'h7fff_ffff, 32'h8000_0000, 32'h1, 32'h7fff_ffff, 1'b1);
      send(OP_QUANTIZE, 32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'h1234_5678, 1'b0);
      send(OP_QUANTIZE, 32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff, 32'h0, 1'b1);
      // zero range: every bound the same value
      send(OP_BOUNDS, 32'h0002_8000, 32'h0002_8000, 32'h0002_8000, 32'h0, 1'b1);
      send(OP_QUANTIZE, 32'h0002_8000, 32'h0009_0000, 32'h0, 32'h0, 1'b0);

      // integer mode, automatic bit count, all four components
      configure(6'sd0, 1'b1, 3'd4, 1'b0);
      send(OP_BOUNDS, 32'h0000_0000, 32'h0003_ffff, 32'h7fff_ffff, 32'h0010_0000, 1'b1);
      send(OP_QUANTIZE, 32'hfffe_0000, 32'h7fff_ffff, 32'h0005_8000, 32'h0000_ffff, 1'b0);
      // negative integer minimum; small negative fraction truncates to zero
      send(OP_BOUNDS, 32'hffff_8000, 32'h0001_0000, 32'h0, 32'h0, 1'b1);
      send(OP_BOUNDS, 32'hffff_0000, 32'h0001_0000, 32'h0, 32'h0, 1'b1);
      send(OP_QUANTIZE, 32'h0001_0000, 32'h0, 32'h0, 32'h0, 1'b0);

      // float mode with zero bits requested
      configure(6'sd0, 1'b0, 3'd2, 1'b0);
      send(OP_BOUNDS, 32'h0001_0000, 32'h0002_0000, 32'h0, 32'h0, 1'b1);
      send(OP_QUANTIZE, 32'h0001_0000, 32'h0002_0000, 32'h0, 32'h0, 1'b0);

      // normals: inside, then beyond the unit range
      configure(6'sd24, 1'b0, 3'd1, 1'b1);
      send(OP_BOUNDS, 32'hffff_0000, 32'h7fff_ffff, 32'h0, 32'h0, 1'b1);
      send(OP_QUANTIZE, 32'hffff_0000, 32'h0, 32'h0, 32'h0, 1'b0);
      send(OP_QUANTIZE, 32'h0001_0000, 32'h0, 32'h0, 32'h0, 1'b0);
      send(OP_QUANTIZE, 32'h0003_0000, 32'h0, 32'h0, 32'h0, 1'b0);
      send(OP_BOUNDS, 32'h0001_0001, 32'h0, 32'h0, 32'h0, 1'b1);
      send(OP_QUANTIZE, 32'h0000_8000, 32'h0, 32'h0, 32'h0, 1'b0);

      // quantization disabled, count zero saturates up to one
      configure(-6'sd1, 1'b0, 3'd0, 1'b0);
      send(OP_BOUNDS, 32'h0001_0000, 32'h0, 32'h0, 32'h0, 1'b1);
      send(OP_QUANTIZE, 32'h0001_0000, 32'h0, 32'h0, 32'h0, 1'b0);

      // random phases: receiver-heavy idling, sender-heavy, then none
      for (int stage = 0; stage < 3; stage++) begin
         send_idle_pct = (stage == 0) ? 13 : (stage == 1) ? 53 : 0;
         recv_idle_pct = (stage == 0) ? 53 : (stage == 1) ? 13 : 0;
         stage_goal = 25 + (stage + 1) * ((ItemGoal + 2) / 3);
         while (requests_sent < stage_goal) begin
            case ($urandom_range(0, 9))
               0: qb = -6'sd32;
               1: qb = 6'sd31;
               2: qb = -6'sd1;
               3: qb = 6'sd0;
               4: qb = 6'sd24;
               default: qb = $urandom_range(1, 24);
            endcase
            im = ($urandom_range(0, 2) == 0);
            nm = ($urandom_range(0, 2) == 0);
            configure(qb, im, $urandom_range(0, 7), nm);
            shape = im ? 2 : nm ? 1 : ($urandom_range(0, 3) == 0) ? 0 : 3;
            // back pressure once: long response hold while requests keep coming
            if (stage == 0 && settings_used == 6) hold_request = 1;
            for (int k = 0; k < 3; k++) run_pass_pair(shape);
         end
      end

      stop_sending();
      wait (pending == 0);
      repeat (300) @(posedge clock);
      $display("covered %0d requests over %0d register settings", requests_sent,
               settings_used);
      $display("including bounds and quantize passes, error cases and a long output stall");
      if (failures == 0)
         $display("vertex_attribute_quantizer_test: PASS");
      else
         $display("vertex_attribute_quantizer_test: FAIL");
      $finish;
   end

endmodule
